### rtl/civ_fr_pkg.sv
// Shared types and constants for the CI-V style frame receiver.
// No dependencies; used by civ_fr_parser and civ_frame_receiver_top.
package civ_fr_pkg;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_START = 3'd1,
    ST_DEST  = 3'd2,
    ST_SRC   = 3'd3,
    ST_DATA  = 3'd4,
    ST_END   = 3'd5,
    ST_ERROR = 3'd6
  } parse_state_e;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_END_BYTE   = 1'b1;

  localparam logic [7:0] StartByteRst = 8'd254;
  localparam logic [7:0] EndByteRst   = 8'd253;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
  } cfg_t;

  typedef struct packed {
    logic [2:0] parse_state;
    logic [7:0] dest_addr;
    logic [7:0] src_addr;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [3:0] payload_index;
    logic       frame_done;
    logic       frame_error;
  } result_t;

endpackage

### rtl/civ_fr_parser.sv
// Next-state and result logic of the frame parser for one received byte.
// Depends on civ_fr_pkg.
module civ_fr_parser #(
  parameter int unsigned BUFFER_DEPTH = 16,
  parameter int unsigned FillW        = $clog2(BUFFER_DEPTH + 1)
) (
  input  civ_fr_pkg::cfg_t         cfg_i,
  input  civ_fr_pkg::parse_state_e state_i,
  input  logic [7:0]               dest_i,
  input  logic [7:0]               src_i,
  input  logic [FillW-1:0]         fill_i,
  input  logic [7:0]               rx_byte_i,
  output civ_fr_pkg::parse_state_e state_o,
  output logic [7:0]               dest_o,
  output logic [7:0]               src_o,
  output logic [FillW-1:0]         fill_o,
  output civ_fr_pkg::result_t      result_o
);
  import civ_fr_pkg::*;

  logic is_start;
  logic is_end;
  logic full;

  assign is_start = (rx_byte_i == cfg_i.start_byte);
  assign is_end   = (rx_byte_i == cfg_i.end_byte);
  assign full     = (fill_i == FillW'(BUFFER_DEPTH));

  always_comb begin
    state_o  = state_i;
    dest_o   = dest_i;
    src_o    = src_i;
    fill_o   = fill_i;
    result_o = '0;
    unique case (state_i)
      ST_IDLE: begin
        if (is_start) begin
          state_o = ST_START;
        end
      end
      ST_START: begin
        if (is_start) begin
          state_o = ST_DEST;
        end else begin
          state_o = ST_ERROR;
          result_o.frame_error = 1'b1;
        end
      end
      ST_DEST: begin
        dest_o  = rx_byte_i;
        state_o = ST_SRC;
      end
      ST_SRC: begin
        src_o   = rx_byte_i;
        fill_o  = '0;
        state_o = ST_DATA;
      end
      ST_DATA: begin
        if (!full) begin
          result_o.payload_valid = 1'b1;
          result_o.payload_byte  = rx_byte_i;
          result_o.payload_index = 4'(fill_i);
          fill_o = fill_i + FillW'(1);
        end else begin
          state_o = ST_ERROR;
          result_o.frame_error = 1'b1;
        end
        if (is_end) begin
          state_o = ST_END;
          result_o.frame_done = 1'b1;
        end
      end
      ST_END, ST_ERROR: begin
        state_o = ST_IDLE;
      end
      default: begin
        state_o = ST_ERROR;
      end
    endcase
    result_o.parse_state = state_o;
    result_o.dest_addr   = dest_o;
    result_o.src_addr    = src_o;
  end

endmodule

### rtl/civ_frame_receiver_top.sv
// Top level of the CI-V style frame receiver: input register, parser state, result register.
// Depends on civ_fr_pkg and civ_fr_parser.
//
//   Channel  Direction  Handshake                  Word
//   cfg      in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
//   rx       in         in_valid_i / in_stall_o    rx_byte_i
//   result   out        out_valid_o / out_stall_i  parse_state_o .. frame_error_o
//
// A byte's result word comes out of the result register after the byte has passed the input register;
// one byte per cycle is sustained while out_stall_i is low. The input register holds a byte until
// the result register can take its result, so one more byte is accepted while a result waits. Reset
// clears the parser state and loads the default start and end bytes.
module civ_frame_receiver_top #(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [civ_fr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   parse_state_o,
  output logic [7:0]                   dest_addr_o,
  output logic [7:0]                   src_addr_o,
  output logic                         payload_valid_o,
  output logic [7:0]                   payload_byte_o,
  output logic [3:0]                   payload_index_o,
  output logic                         frame_done_o,
  output logic                         frame_error_o
);
  import civ_fr_pkg::*;

  localparam int unsigned FillW = $clog2(BUFFER_DEPTH + 1);

  cfg_t         cfg_q;
  parse_state_e state_q, state_d;
  logic [7:0]   dest_q, dest_d;
  logic [7:0]   src_q, src_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]   byte_q;
  logic         byte_valid_q;
  result_t      result_q, result_d;
  logic         out_valid_q;
  logic         advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= StartByteRst;
      cfg_q.end_byte   <= EndByteRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_BYTE: cfg_q.start_byte <= cfg_wdata_i;
        CFG_END_BYTE:   cfg_q.end_byte   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign advance    = byte_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = byte_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      byte_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  civ_fr_parser #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .FillW       (FillW)
  ) u_parser (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .dest_i   (dest_q),
    .src_i    (src_q),
    .fill_i   (fill_q),
    .rx_byte_i(byte_q),
    .state_o  (state_d),
    .dest_o   (dest_d),
    .src_o    (src_d),
    .fill_o   (fill_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dest_q  <= '0;
      src_q   <= '0;
      fill_q  <= '0;
    end else if (advance) begin
      state_q <= state_d;
      dest_q  <= dest_d;
      src_q   <= src_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign parse_state_o   = result_q.parse_state;
  assign dest_addr_o     = result_q.dest_addr;
  assign src_addr_o      = result_q.src_addr;
  assign payload_valid_o = result_q.payload_valid;
  assign payload_byte_o  = result_q.payload_byte;
  assign payload_index_o = result_q.payload_index;
  assign frame_done_o    = result_q.frame_done;
  assign frame_error_o   = result_q.frame_error;

endmodule
